/* sv/sbd_pkg.sv */
package sbd_pkg;

    localparam int MAX_EQUATIONS = 256;
    localparam int MAX_BLOCKS    = 64;
    localparam int STORE_DEPTH   = 4096;
    localparam int VALUE_WIDTH   = 64;

    localparam int EQ_W    = 20;
    localparam int SLOT_W  = 8;
    localparam int FIRST_W = 9;
    localparam int BCNT_W  = 7;
    localparam int BLK_W   = $clog2(MAX_BLOCKS);
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int BASE_W  = 12;
    localparam int PROD_W  = SLOT_W + FIRST_W;

    typedef enum logic [1:0] {
        CMD_LOAD_EQ  = 2'd0,
        CMD_LOAD_BLK = 2'd1,
        CMD_WRITE    = 2'd2,
        CMD_READ     = 2'd3
    } sbd_cmd_t;

    typedef struct packed {
        logic               eq_we;
        logic [SLOT_W-1:0]  eq_addr;
        logic [EQ_W-1:0]    eq_data;
        logic               first_we;
        logic [BCNT_W-1:0]  first_addr;
        logic [FIRST_W-1:0] first_data;
    } sbd_tbl_wr_t;

    typedef struct packed {
        logic               we;
        logic [BLK_W-1:0]   addr;
        logic [BASE_W-1:0]  data;
    } sbd_base_wr_t;

    typedef struct packed {
        logic               found;
        logic [BLK_W-1:0]   blk;
        logic [SLOT_W-1:0]  offset;
        logic [FIRST_W-1:0] size;
    } sbd_loc_res_t;

    typedef struct packed {
        logic               wr;
        logic [BLK_W-1:0]   blk;
        logic [SLOT_W-1:0]  roff;
        logic [SLOT_W-1:0]  coff;
        logic [FIRST_W-1:0] size;
    } sbd_st_req_t;

endpackage

/* sv/sparse_block_diag_element_access_unit.sv */
// A load transaction moves from acceptance to the done state, and its result is registered once the output is free.
// An access runs one or two table searches, each visiting blocks in turn and comparing their
// slots through one shared comparator, then an address multiply and a storage access; the
// result is then registered at the output.
// Throughput: one transaction at a time; the next is taken once the result is latched.
// Reset clears block_count and control state; tables hold nothing until loaded.
module sparse_block_diag_element_access_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sbd_pkg::BCNT_W-1:0]       cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_cmd,
    input  logic [sbd_pkg::SLOT_W-1:0]       s_slot_index,
    input  logic [sbd_pkg::EQ_W-1:0]         s_row_eq,
    input  logic [sbd_pkg::EQ_W-1:0]         s_col_eq,
    input  logic [sbd_pkg::FIRST_W-1:0]      s_first_slot,
    input  logic [sbd_pkg::BASE_W-1:0]       s_storage_base,
    input  logic [sbd_pkg::VALUE_WIDTH-1:0]  s_data_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sbd_pkg::VALUE_WIDTH-1:0]  m_read_value,
    output logic                             m_status
);
    import sbd_pkg::*;

    typedef enum logic [7:0] {
        T_IDLE     = 8'b0000_0001,
        T_ROW_GO   = 8'b0000_0010,
        T_ROW_WAIT = 8'b0000_0100,
        T_COL_GO   = 8'b0000_1000,
        T_COL_WAIT = 8'b0001_0000,
        T_ST_GO    = 8'b0010_0000,
        T_ST_WAIT  = 8'b0100_0000,
        T_DONE     = 8'b1000_0000
    } top_state_t;

    top_state_t             state_reg, state_next;
    logic [BCNT_W-1:0]      block_count_reg;
    logic [BCNT_W-1:0]      blk_limit;
    sbd_cmd_t               cmd_reg;
    logic [EQ_W-1:0]        row_reg;
    logic [EQ_W-1:0]        col_reg;
    logic [VALUE_WIDTH-1:0] data_reg;
    logic [BLK_W-1:0]       rb_reg;
    logic [SLOT_W-1:0]      roff_reg;
    logic [SLOT_W-1:0]      coff_reg;
    logic [FIRST_W-1:0]     size_reg;
    logic [VALUE_WIDTH-1:0] res_value_reg;
    logic                   res_status_reg;
    logic                   m_valid_reg;
    logic [VALUE_WIDTH-1:0] m_read_value_reg;
    logic                   m_status_reg;

    logic                   s_accept;
    logic                   out_load;
    sbd_cmd_t               s_cmd_code;
    sbd_tbl_wr_t            tbl_wr;
    sbd_base_wr_t           base_wr;
    logic                   loc_start;
    logic [EQ_W-1:0]        loc_target;
    logic                   loc_done;
    sbd_loc_res_t           loc_res;
    logic                   st_start;
    sbd_st_req_t            st_req;
    logic                   st_done;
    logic [VALUE_WIDTH-1:0] st_rd_data;

    assign s_cmd_code = sbd_cmd_t'(s_cmd);
    assign s_ready    = (state_reg == T_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign out_load   = (state_reg == T_DONE) && (!m_valid_reg || m_ready);
    assign blk_limit  = (block_count_reg > BCNT_W'(MAX_BLOCKS)) ?
                        BCNT_W'(MAX_BLOCKS) : block_count_reg;

    always_comb begin
        tbl_wr.eq_we      = s_accept && (s_cmd_code == CMD_LOAD_EQ);
        tbl_wr.eq_addr    = s_slot_index;
        tbl_wr.eq_data    = s_row_eq;
        tbl_wr.first_we   = s_accept && (s_cmd_code == CMD_LOAD_BLK) &&
                            (s_slot_index <= SLOT_W'(MAX_BLOCKS));
        tbl_wr.first_addr = s_slot_index[BCNT_W-1:0];
        tbl_wr.first_data = s_first_slot;
        base_wr.we        = s_accept && (s_cmd_code == CMD_LOAD_BLK) &&
                            (s_slot_index < SLOT_W'(MAX_BLOCKS));
        base_wr.addr      = s_slot_index[BLK_W-1:0];
        base_wr.data      = s_storage_base;
    end

    assign loc_start  = (state_reg == T_ROW_GO) || (state_reg == T_COL_GO);
    assign loc_target = (state_reg == T_COL_GO) ? col_reg : row_reg;
    assign st_start   = (state_reg == T_ST_GO);

    always_comb begin
        st_req.wr   = (cmd_reg == CMD_WRITE);
        st_req.blk  = rb_reg;
        st_req.roff = roff_reg;
        st_req.coff = coff_reg;
        st_req.size = size_reg;
    end

    sbd_locate u_locate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tbl_wr    (tbl_wr),
        .start     (loc_start),
        .target    (loc_target),
        .blk_limit (blk_limit),
        .done      (loc_done),
        .res       (loc_res)
    );

    sbd_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .base_wr (base_wr),
        .start   (st_start),
        .req     (st_req),
        .wr_data (data_reg),
        .done    (st_done),
        .rd_data (st_rd_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (s_accept) begin
                    if (s_cmd_code == CMD_WRITE || s_cmd_code == CMD_READ) begin
                        state_next = T_ROW_GO;
                    end else begin
                        state_next = T_DONE;
                    end
                end
            end
            T_ROW_GO: state_next = T_ROW_WAIT;
            T_ROW_WAIT: begin
                if (loc_done) begin
                    state_next = loc_res.found ? T_COL_GO : T_DONE;
                end
            end
            T_COL_GO: state_next = T_COL_WAIT;
            T_COL_WAIT: begin
                if (loc_done) begin
                    state_next = (loc_res.found && loc_res.blk == rb_reg) ? T_ST_GO : T_DONE;
                end
            end
            T_ST_GO: state_next = T_ST_WAIT;
            T_ST_WAIT: begin
                if (st_done) begin
                    state_next = T_DONE;
                end
            end
            T_DONE: begin
                if (out_load) begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= T_IDLE;
            block_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                block_count_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg        <= s_cmd_code;
            row_reg        <= s_row_eq;
            col_reg        <= s_col_eq;
            data_reg       <= s_data_value;
            res_value_reg  <= '0;
            res_status_reg <= 1'b0;
        end
        if (state_reg == T_ROW_WAIT && loc_done) begin
            rb_reg   <= loc_res.blk;
            roff_reg <= loc_res.offset;
            size_reg <= loc_res.size;
            if (!loc_res.found) begin
                res_status_reg <= 1'b1;
            end
        end
        if (state_reg == T_COL_WAIT && loc_done) begin
            coff_reg <= loc_res.offset;
            if (!loc_res.found || loc_res.blk != rb_reg) begin
                res_status_reg <= 1'b1;
            end
        end
        if (state_reg == T_ST_WAIT && st_done && cmd_reg == CMD_READ) begin
            res_value_reg <= st_rd_data;
        end
        if (out_load) begin
            m_read_value_reg <= res_value_reg;
            m_status_reg     <= res_status_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;

    a_loc_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        loc_done |-> (state_reg == T_ROW_WAIT || state_reg == T_COL_WAIT))
        else $error("search finished outside a search wait state");

    a_st_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        st_done |-> (state_reg == T_ST_WAIT))
        else $error("storage access finished outside its wait state");

    a_refused_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_read_value == '0))
        else $error("refused transaction returned nonzero data");

    a_single_transaction: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("input taken while a transaction is in flight");

endmodule

/* sv/sbd_locate.sv */
module sbd_locate (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sbd_pkg::sbd_tbl_wr_t        tbl_wr,
    input  logic                        start,
    input  logic [sbd_pkg::EQ_W-1:0]    target,
    input  logic [sbd_pkg::BCNT_W-1:0]  blk_limit,
    output logic                        done,
    output sbd_pkg::sbd_loc_res_t       res
);
    import sbd_pkg::*;

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_BLK  = 4'b0010,
        L_BND  = 4'b0100,
        L_CMP  = 4'b1000
    } loc_state_t;

    loc_state_t         state_reg, state_next;
    logic [BCNT_W-1:0]  blk_reg, blk_next;
    logic [FIRST_W-1:0] slot_reg, slot_next;
    logic [FIRST_W-1:0] lo_reg, lo_next;
    logic [FIRST_W-1:0] hic_reg, hic_next;
    logic [FIRST_W-1:0] size_reg, size_next;
    logic [EQ_W-1:0]    target_reg, target_next;
    logic               done_reg, done_next;
    sbd_loc_res_t       res_reg, res_next;

    logic [EQ_W-1:0]    eq_mem [MAX_EQUATIONS];
    logic [FIRST_W-1:0] first_mem [MAX_BLOCKS+1];
    logic [EQ_W-1:0]    eq_rd_reg;
    logic [FIRST_W-1:0] first_lo_rd_reg;
    logic [FIRST_W-1:0] first_hi_rd_reg;

    logic [FIRST_W-1:0] hi_clamp;
    logic [FIRST_W-1:0] slot_inc;
    logic [SLOT_W-1:0]  eq_rd_addr;
    logic [BCNT_W-1:0]  blk_inc;

    assign hi_clamp   = (first_hi_rd_reg > FIRST_W'(MAX_EQUATIONS)) ?
                        FIRST_W'(MAX_EQUATIONS) : first_hi_rd_reg;
    assign slot_inc   = slot_reg + 1'b1;
    assign blk_inc    = blk_reg + 1'b1;
    assign eq_rd_addr = (state_reg == L_BND) ? first_lo_rd_reg[SLOT_W-1:0]
                                             : slot_inc[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (tbl_wr.eq_we) begin
            eq_mem[tbl_wr.eq_addr] <= tbl_wr.eq_data;
        end
        eq_rd_reg <= eq_mem[eq_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (tbl_wr.first_we) begin
            first_mem[tbl_wr.first_addr] <= tbl_wr.first_data;
        end
        first_lo_rd_reg <= first_mem[blk_reg];
        first_hi_rd_reg <= first_mem[blk_inc];
    end

    always_comb begin
        state_next  = state_reg;
        blk_next    = blk_reg;
        slot_next   = slot_reg;
        lo_next     = lo_reg;
        hic_next    = hic_reg;
        size_next   = size_reg;
        target_next = target_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            L_IDLE: begin
                if (start) begin
                    target_next = target;
                    blk_next    = '0;
                    state_next  = L_BLK;
                end
            end
            L_BLK: begin
                if (blk_reg >= blk_limit) begin
                    done_next      = 1'b1;
                    res_next.found = 1'b0;
                    state_next     = L_IDLE;
                end else begin
                    state_next = L_BND;
                end
            end
            L_BND: begin
                if (first_lo_rd_reg >= hi_clamp) begin
                    blk_next   = blk_inc;
                    state_next = L_BLK;
                end else begin
                    slot_next  = first_lo_rd_reg;
                    lo_next    = first_lo_rd_reg;
                    hic_next   = hi_clamp;
                    size_next  = first_hi_rd_reg - first_lo_rd_reg;
                    state_next = L_CMP;
                end
            end
            L_CMP: begin
                if (eq_rd_reg == target_reg) begin
                    done_next       = 1'b1;
                    res_next.found  = 1'b1;
                    res_next.blk    = blk_reg[BLK_W-1:0];
                    res_next.offset = SLOT_W'(slot_reg - lo_reg);
                    res_next.size   = size_reg;
                    state_next      = L_IDLE;
                end else if (slot_inc >= hic_reg) begin
                    blk_next   = blk_inc;
                    state_next = L_BLK;
                end else begin
                    slot_next = slot_inc;
                end
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg    <= blk_next;
        slot_reg   <= slot_next;
        lo_reg     <= lo_next;
        hic_reg    <= hic_next;
        size_reg   <= size_next;
        target_reg <= target_next;
        res_reg    <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* sv/sbd_store.sv */
module sbd_store (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sbd_pkg::sbd_base_wr_t            base_wr,
    input  logic                             start,
    input  sbd_pkg::sbd_st_req_t             req,
    input  logic [sbd_pkg::VALUE_WIDTH-1:0]  wr_data,
    output logic                             done,
    output logic [sbd_pkg::VALUE_WIDTH-1:0]  rd_data
);
    import sbd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ACC  = 4'b0100,
        S_DONE = 4'b1000
    } st_state_t;

    st_state_t              state_reg, state_next;
    sbd_st_req_t            req_reg;
    logic [VALUE_WIDTH-1:0] data_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [BASE_W-1:0]      base_rd_reg;
    logic [VALUE_WIDTH-1:0] rd_reg;
    logic [ADDR_W-1:0]      addr;

    logic [BASE_W-1:0]      base_mem [MAX_BLOCKS];
    logic [VALUE_WIDTH-1:0] value_mem [STORE_DEPTH];

    assign addr = ADDR_W'(base_rd_reg) + ADDR_W'(req_reg.roff) + prod_reg[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (base_wr.we) begin
            base_mem[base_wr.addr] <= base_wr.data;
        end
        base_rd_reg <= base_mem[req_reg.blk];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_ACC && req_reg.wr) begin
            value_mem[addr] <= data_reg;
        end
        rd_reg <= value_mem[addr];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_MUL;
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && start) begin
            req_reg  <= req;
            data_reg <= wr_data;
        end
        prod_reg <= req_reg.coff * req_reg.size;
    end

    assign done    = (state_reg == S_DONE);
    assign rd_data = rd_reg;

endmodule
